// File: hw/rtl/mbs_pkg.sv
package mbs_pkg;

   localparam int PIXEL_INDEX_W = 12;
   localparam int CHAN_W = 8;
   localparam int RGB_W = 3 * CHAN_W;
   localparam int THRESHOLD_W = 8;
   localparam int RANK_W = 4;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 24;

   localparam int HISTORY_FRAMES_DEFAULT = 5;
   localparam int FRAME_PIXELS_DEFAULT = 4096;

   localparam logic [THRESHOLD_W-1:0] THRESHOLD_RESET = 8'd32;
   localparam logic [RANK_W-1:0] RANK_RESET = 4'd2;

   localparam logic CSR_THRESHOLD_IDX = 1'b0;
   localparam logic CSR_RANK_IDX = 1'b1;

   localparam logic MODE_LEARN = 1'b0;
   localparam logic MODE_DETECT = 1'b1;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
   } rgb_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE_Q,
      ST_REDUCE_R,
      ST_ACCESS,
      ST_LOAD,
      ST_SORT,
      ST_FINISH
   } mbs_state_type;

   typedef struct packed {
      logic capture;
      logic reduce_q;
      logic reduce_r;
      logic access;
      logic load;
      logic sort_step;
      logic finish;
   } mbs_cmd_type;

   typedef struct packed {
      logic is_detect;
      logic sort_done;
      logic out_free;
   } mbs_status_type;

endpackage

// File: hw/rtl/median_background_subtractor_unit.sv
// Flow: a word is captured in IDLE and passes REDUCE_Q, REDUCE_R, ACCESS and LOAD; a detect word
// then goes to FINISH, a learn word first runs SORT over the filled slots up to the clamped rank.
// FINISH waits for a free output register; no new word is taken until the FSM is back in IDLE.
// The sort is an exchange sort doing compare-exchanges by channel sum on a register ring.
// Reset is synchronous: slot pointer, fill count, handshakes and registers (32, 2) clear;
// the history and background memories are not cleared.
module median_background_subtractor_unit import mbs_pkg::*; #(
   parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEFAULT,
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // pixel_index[11:0], red_in[19:12], green_in[27:20], blue_in[35:28], zero[39:36]
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // mode
   input  logic                  req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // red_out[7:0], green_out[15:8], blue_out[23:16]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // foreground
   output logic                  rsp_tuser,
   output logic                  rsp_tlast,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   logic [THRESHOLD_W-1:0] threshold_ff;
   logic [RANK_W-1:0]      rank_ff;
   logic                   csr_write;
   logic                   csr_index;

   mbs_cmd_type    cmd;
   mbs_status_type status;
   rgb_type        req_pixel;
   rgb_type        rsp_pixel;

   assign csr_pready = 1'b1;
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index = csr_paddr[2];

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         rank_ff <= RANK_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_THRESHOLD_IDX: threshold_ff <= csr_pwdata[THRESHOLD_W-1:0];
            CSR_RANK_IDX: rank_ff <= csr_pwdata[RANK_W-1:0];
            default: begin
               threshold_ff <= threshold_ff;
            end
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         CSR_THRESHOLD_IDX: csr_prdata = CSR_DATA_W'(threshold_ff);
         CSR_RANK_IDX: csr_prdata = CSR_DATA_W'(rank_ff);
         default: csr_prdata = '0;
      endcase
   end

   assign req_pixel.red = req_tdata[19:12];
   assign req_pixel.green = req_tdata[27:20];
   assign req_pixel.blue = req_tdata[35:28];

   mbs_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .status(status),
      .cmd(cmd)
   );

   mbs_datapath #(
      .HISTORY_FRAMES(HISTORY_FRAMES),
      .FRAME_PIXELS(FRAME_PIXELS)
   ) u_datapath (
      .clock(clock),
      .reset(reset),
      .cmd(cmd),
      .status(status),
      .req_mode(req_tuser),
      .req_pixel_index(req_tdata[PIXEL_INDEX_W-1:0]),
      .req_pixel(req_pixel),
      .req_frame_end(req_tlast),
      .diff_threshold(threshold_ff),
      .central_rank(rank_ff),
      .rsp_tready(rsp_tready),
      .rsp_valid(rsp_tvalid),
      .rsp_pixel(rsp_pixel),
      .rsp_foreground(rsp_tuser),
      .rsp_frame_end(rsp_tlast)
   );

   assign rsp_tdata = {rsp_pixel.blue, rsp_pixel.green, rsp_pixel.red};

endmodule

// File: hw/rtl/mbs_ram.sv
module mbs_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 4096
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// File: hw/rtl/mbs_ctrl.sv
module mbs_ctrl import mbs_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_tvalid,
   output logic           req_tready,
   input  mbs_status_type status,
   output mbs_cmd_type    cmd
);

   mbs_state_type state_ff;
   mbs_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in = ST_REDUCE_Q;
            end
         end
         ST_REDUCE_Q: state_in = ST_REDUCE_R;
         ST_REDUCE_R: state_in = ST_ACCESS;
         ST_ACCESS: state_in = ST_LOAD;
         ST_LOAD: begin
            state_in = status.is_detect ? ST_FINISH : ST_SORT;
         end
         ST_SORT: begin
            if (status.sort_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.capture = req_tvalid;
         end
         ST_REDUCE_Q: cmd.reduce_q = 1'b1;
         ST_REDUCE_R: cmd.reduce_r = 1'b1;
         ST_ACCESS: cmd.access = 1'b1;
         ST_LOAD: cmd.load = 1'b1;
         ST_SORT: cmd.sort_step = 1'b1;
         ST_FINISH: cmd.finish = status.out_free;
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

// File: hw/rtl/mbs_datapath.sv
module mbs_datapath import mbs_pkg::*; #(
   parameter int HISTORY_FRAMES = HISTORY_FRAMES_DEFAULT,
   parameter int FRAME_PIXELS = FRAME_PIXELS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  mbs_cmd_type              cmd,
   output mbs_status_type           status,
   input  logic                     req_mode,
   input  logic [PIXEL_INDEX_W-1:0] req_pixel_index,
   input  rgb_type                  req_pixel,
   input  logic                     req_frame_end,
   input  logic [THRESHOLD_W-1:0]   diff_threshold,
   input  logic [RANK_W-1:0]        central_rank,
   input  logic                     rsp_tready,
   output logic                     rsp_valid,
   output rgb_type                  rsp_pixel,
   output logic                     rsp_foreground,
   output logic                     rsp_frame_end
);

   localparam int PIX_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int SLOT_W = (HISTORY_FRAMES > 1) ? $clog2(HISTORY_FRAMES) : 1;
   localparam int CNT_W = $clog2(HISTORY_FRAMES + 1);
   localparam int CMP_W = (CNT_W > RANK_W) ? CNT_W : RANK_W;
   localparam int INDEX_RANGE = 2 ** PIXEL_INDEX_W;
   localparam int RECIP_SHIFT = 2 * PIXEL_INDEX_W;
   localparam int RECIP_W = RECIP_SHIFT + 1;
   localparam int PROD_W = PIXEL_INDEX_W + RECIP_W;

   logic                     in_mode_ff;
   logic [PIXEL_INDEX_W-1:0] in_index_ff;
   rgb_type                  in_pixel_ff;
   logic                     in_frame_end_ff;
   logic [PIX_W-1:0]         pix_ff;
   logic [PIX_W-1:0]         pix_in;

   logic [SLOT_W-1:0] slot_ff;
   logic [CNT_W-1:0]  fill_ff;

   rgb_type           head_ff, head_in;
   rgb_type           ring_ff [HISTORY_FRAMES];
   rgb_type           ring_in [HISTORY_FRAMES];
   rgb_type           ring_up [HISTORY_FRAMES];
   rgb_type           vals [HISTORY_FRAMES];
   logic [SLOT_W-1:0] ring_len_ff, ring_len_in;
   logic [SLOT_W-1:0] steps_left_ff, steps_left_in;
   logic [SLOT_W-1:0] passes_left_ff, passes_left_in;

   rgb_type res_pixel_ff;
   logic    res_fg_ff;

   logic                  rsp_valid_ff;
   rgb_type               rsp_pixel_ff;
   logic                  rsp_fg_ff;
   logic                  rsp_frame_end_ff;

   logic [RGB_W-1:0] hist_rd [HISTORY_FRAMES];
   logic [RGB_W-1:0] bg_rd;
   rgb_type          bg_pixel;

   logic [CNT_W-1:0]  count;
   logic [SLOT_W-1:0] rank;
   logic              swap;
   rgb_type           pushed;
   logic              detect_fg;
   logic [CHAN_W-1:0] diff_red, diff_green, diff_blue;
   logic              is_learn;

   function automatic logic [CHAN_W+1:0] luma(rgb_type p);
      luma = (CHAN_W+2)'(p.red) + (CHAN_W+2)'(p.green) + (CHAN_W+2)'(p.blue);
   endfunction

   assign is_learn = (in_mode_ff == MODE_LEARN);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         in_mode_ff <= req_mode;
         in_index_ff <= req_pixel_index;
         in_pixel_ff <= req_pixel;
         in_frame_end_ff <= req_frame_end;
      end
      if (cmd.reduce_r) begin
         pix_ff <= pix_in;
      end
   end

   generate
      if (FRAME_PIXELS >= INDEX_RANGE) begin : g_direct
         assign pix_in = PIX_W'(in_index_ff);
      end else begin : g_reduce
         localparam longint RECIP =
            ((64'd1 << RECIP_SHIFT) + FRAME_PIXELS - 1) / FRAME_PIXELS;
         logic [PIXEL_INDEX_W-1:0]   quot_ff;
         logic [PROD_W-1:0]          recip_prod;
         logic [2*PIXEL_INDEX_W-1:0] back_prod;
         logic [PIXEL_INDEX_W-1:0]   remainder;

         assign recip_prod = PROD_W'(in_index_ff) * PROD_W'(RECIP_W'(RECIP));
         assign back_prod = (2*PIXEL_INDEX_W)'(quot_ff)
                            * (2*PIXEL_INDEX_W)'(PIXEL_INDEX_W'(FRAME_PIXELS));
         assign remainder = in_index_ff - back_prod[PIXEL_INDEX_W-1:0];
         assign pix_in = PIX_W'(remainder);

         always_ff @(posedge clock) begin
            if (cmd.reduce_q) begin
               quot_ff <= recip_prod[RECIP_SHIFT +: PIXEL_INDEX_W];
            end
         end
      end
   endgenerate

   genvar gs;
   generate
      for (gs = 0; gs < HISTORY_FRAMES; gs++) begin : g_hist
         mbs_ram #(
            .WIDTH(RGB_W),
            .DEPTH(FRAME_PIXELS)
         ) u_hist_ram (
            .clock(clock),
            .we(cmd.access && is_learn && (slot_ff == SLOT_W'(gs))),
            .waddr(pix_ff),
            .wdata(in_pixel_ff),
            .raddr(pix_ff),
            .rdata(hist_rd[gs])
         );
      end
   endgenerate

   mbs_ram #(
      .WIDTH(RGB_W),
      .DEPTH(FRAME_PIXELS)
   ) u_bg_ram (
      .clock(clock),
      .we(cmd.finish && is_learn),
      .waddr(pix_ff),
      .wdata(res_pixel_ff),
      .raddr(pix_ff),
      .rdata(bg_rd)
   );

   assign bg_pixel = rgb_type'(bg_rd);

   assign count = (fill_ff < CNT_W'(HISTORY_FRAMES)) ? fill_ff + 1'b1
                                                     : CNT_W'(HISTORY_FRAMES);
   assign rank = (CMP_W'(central_rank) < CMP_W'(count)) ? SLOT_W'(central_rank)
                                                        : SLOT_W'(count - 1'b1);

   assign diff_red = (in_pixel_ff.red > bg_pixel.red)
                     ? in_pixel_ff.red - bg_pixel.red : '0;
   assign diff_green = (in_pixel_ff.green > bg_pixel.green)
                       ? in_pixel_ff.green - bg_pixel.green : '0;
   assign diff_blue = (in_pixel_ff.blue > bg_pixel.blue)
                      ? in_pixel_ff.blue - bg_pixel.blue : '0;
   assign detect_fg = (diff_red >= diff_threshold) || (diff_green >= diff_threshold)
                      || (diff_blue >= diff_threshold);

   assign swap = luma(head_ff) > luma(ring_ff[0]);
   assign pushed = swap ? head_ff : ring_ff[0];

   always_comb begin
      for (int s = 0; s < HISTORY_FRAMES; s++) begin
         vals[s] = (is_learn && (slot_ff == SLOT_W'(s))) ? in_pixel_ff
                                                         : rgb_type'(hist_rd[s]);
      end
      ring_up[HISTORY_FRAMES-1] = '0;
      for (int k = 0; k < HISTORY_FRAMES - 1; k++) begin
         ring_up[k] = ring_ff[k + 1];
      end
   end

   always_comb begin
      head_in = head_ff;
      ring_in = ring_ff;
      ring_len_in = ring_len_ff;
      steps_left_in = steps_left_ff;
      passes_left_in = passes_left_ff;
      if (cmd.load) begin
         head_in = vals[0];
         ring_in[HISTORY_FRAMES-1] = '0;
         for (int k = 0; k < HISTORY_FRAMES - 1; k++) begin
            ring_in[k] = vals[k + 1];
         end
         ring_len_in = SLOT_W'(count - 1'b1);
         steps_left_in = SLOT_W'(count - 1'b1);
         passes_left_in = rank;
      end else if (cmd.sort_step) begin
         if (steps_left_ff != '0) begin
            head_in = swap ? ring_ff[0] : head_ff;
            for (int k = 0; k < HISTORY_FRAMES; k++) begin
               ring_in[k] = (SLOT_W'(k) == SLOT_W'(ring_len_ff - 1'b1)) ? pushed
                                                                       : ring_up[k];
            end
            steps_left_in = steps_left_ff - 1'b1;
         end else if (passes_left_ff != '0) begin
            head_in = ring_ff[0];
            ring_in = ring_up;
            ring_len_in = ring_len_ff - 1'b1;
            steps_left_in = ring_len_ff - 1'b1;
            passes_left_in = passes_left_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      ring_ff <= ring_in;
      if (reset) begin
         ring_len_ff <= '0;
         steps_left_ff <= '0;
         passes_left_ff <= '0;
      end else begin
         ring_len_ff <= ring_len_in;
         steps_left_ff <= steps_left_in;
         passes_left_ff <= passes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         if (is_learn) begin
            res_fg_ff <= 1'b0;
         end else begin
            res_fg_ff <= detect_fg;
            res_pixel_ff <= detect_fg ? in_pixel_ff : '0;
         end
      end else if (cmd.sort_step && status.sort_done) begin
         res_pixel_ff <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff <= '0;
         fill_ff <= '0;
      end else if (cmd.finish && is_learn && in_frame_end_ff) begin
         slot_ff <= (slot_ff == SLOT_W'(HISTORY_FRAMES - 1)) ? '0 : slot_ff + 1'b1;
         if (fill_ff < CNT_W'(HISTORY_FRAMES)) begin
            fill_ff <= fill_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_pixel_ff <= res_pixel_ff;
         rsp_fg_ff <= res_fg_ff;
         rsp_frame_end_ff <= in_frame_end_ff;
      end
   end

   assign status.is_detect = (in_mode_ff == MODE_DETECT);
   assign status.sort_done = (steps_left_ff == '0) && (passes_left_ff == '0);
   assign status.out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_foreground = rsp_fg_ff;
   assign rsp_frame_end = rsp_frame_end_ff;

   a_rank_in_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_step |-> passes_left_ff <= ring_len_ff)
      else $error("rank pass count exceeds ring length");

   a_steps_in_ring: assert property (@(posedge clock) disable iff (reset)
      cmd.sort_step |-> steps_left_ff <= ring_len_ff)
      else $error("compare steps exceed ring length");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= CNT_W'(HISTORY_FRAMES))
      else $error("filled frame count out of range");

   a_slot_bound: assert property (@(posedge clock) disable iff (reset)
      slot_ff <= SLOT_W'(HISTORY_FRAMES - 1))
      else $error("write slot out of range");

endmodule

// File: sim/median_background_subtractor_unit_tb.sv
module median_background_subtractor_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mbs_pkg::*;

   localparam int HIST = HISTORY_FRAMES_DEFAULT;
   localparam int PIXELS = FRAME_PIXELS_DEFAULT;
   localparam int POOL_SIZE = 32;
   localparam int TOTAL_WORDS = 1650;
   localparam int PHASES = 8;
   localparam int DRAIN_CYCLES = 24;
   localparam int STALL_LIMIT = 2000;

   localparam logic [PIXEL_INDEX_W-1:0] PIX_FIRST = 12'h000;
   localparam logic [PIXEL_INDEX_W-1:0] PIX_LAST = 12'hFFF;
   localparam logic [PIXEL_INDEX_W-1:0] PIX_CHECKER = 12'hAAA;
   localparam logic [PIXEL_INDEX_W-1:0] TIE_PIXEL = 12'h555;

   typedef struct packed {
      rgb_type color;
      logic foreground;
      logic frame_end;
   } pixel_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic req_tuser = MODE_LEARN;
   logic req_tlast = 1'b0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tuser;
   logic rsp_tlast;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   rgb_type history_copy [HIST][PIXELS];
   bit history_written [HIST][PIXELS];
   rgb_type background_copy [PIXELS];
   bit background_written [PIXELS];
   int unsigned slot_now = 0;
   int unsigned frames_done = 0;
   logic [THRESHOLD_W-1:0] threshold_now = THRESHOLD_RESET;
   logic [RANK_W-1:0] rank_now = RANK_RESET;

   pixel_result_type expected_results [$];
   logic [PIXEL_INDEX_W-1:0] pixel_pool [POOL_SIZE];

   int fail_count = 0;
   int words_sent = 0;
   int learn_words = 0;
   int detect_words = 0;
   int results_checked = 0;
   int foreground_seen = 0;
   int settings_used = 0;
   bit send_gaps = 1'b1;
   bit steady_tail = 1'b0;
   bit rsp_stalls_on = 1'b1;
   int ready_hold = 0;
   int idle_cycles = 0;

   median_background_subtractor_unit #(
      .HISTORY_FRAMES(HIST),
      .FRAME_PIXELS(PIXELS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .rsp_tlast(rsp_tlast),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [9:0] channel_sum(rgb_type p);
      return 10'(p.red) + 10'(p.green) + 10'(p.blue);
   endfunction

   // Updates the shadow history and background and returns the word the block must produce.
   function automatic pixel_result_type subtract_background(logic mode,
         logic [PIXEL_INDEX_W-1:0] pix, rgb_type px, logic fe);
      rgb_type ring [HIST];
      rgb_type bg;
      rgb_type held;
      pixel_result_type res;
      int count;
      int rank;
      logic [CHAN_W-1:0] dr, dg, db;
      res.color = '0;
      res.foreground = 1'b0;
      res.frame_end = fe;
      if (mode == MODE_LEARN) begin
         history_copy[slot_now][pix] = px;
         history_written[slot_now][pix] = 1'b1;
         count = (frames_done < HIST) ? frames_done + 1 : HIST;
         for (int i = 0; i < count; i++) ring[i] = history_copy[i][pix];
         for (int i = 0; i < count; i++) begin
            for (int j = i + 1; j < count; j++) begin
               if (channel_sum(ring[i]) > channel_sum(ring[j])) begin
                  held = ring[j];
                  ring[j] = ring[i];
                  ring[i] = held;
               end
            end
         end
         rank = (int'(rank_now) < count) ? int'(rank_now) : count - 1;
         background_copy[pix] = ring[rank];
         background_written[pix] = 1'b1;
         res.color = ring[rank];
         if (fe) begin
            slot_now = (slot_now + 1) % HIST;
            if (frames_done < HIST) frames_done++;
         end
      end else begin
         bg = background_copy[pix];
         dr = (px.red > bg.red) ? px.red - bg.red : 8'd0;
         dg = (px.green > bg.green) ? px.green - bg.green : 8'd0;
         db = (px.blue > bg.blue) ? px.blue - bg.blue : 8'd0;
         res.foreground = (dr >= threshold_now) || (dg >= threshold_now) ||
               (db >= threshold_now);
         if (res.foreground) res.color = px;
      end
      return res;
   endfunction

   function automatic bit learn_allowed(logic [PIXEL_INDEX_W-1:0] pix);
      int count;
      count = (frames_done < HIST) ? frames_done + 1 : HIST;
      for (int s = 0; s < count; s++) begin
         if (s != slot_now && !history_written[s][pix]) return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic logic [CHAN_W-1:0] probe_channel(logic [CHAN_W-1:0] base);
      int v;
      case ($urandom_range(0, 4))
         0: v = $urandom_range(0, 255);
         1: v = int'(base) + int'(threshold_now) - 1 + int'($urandom_range(0, 2));
         2: v = int'(base) - int'($urandom_range(0, 8));
         3: v = $urandom_range(0, 1) ? 255 : 0;
         default: v = int'(base) + int'($urandom_range(0, 8));
      endcase
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[CHAN_W-1:0];
   endfunction

   // The tie pixel always gets a color of the same channel sum, so its rank picks a slot.
   function automatic rgb_type learn_color(logic [PIXEL_INDEX_W-1:0] pix);
      rgb_type base;
      rgb_type c;
      base = background_written[pix] ? background_copy[pix] : rgb_type'(24'($urandom));
      if (pix == TIE_PIXEL) begin
         c.red = 8'(10 * slot_now);
         c.green = 8'd40;
         c.blue = 8'(100 - 10 * slot_now);
      end else if ($urandom_range(0, 4) == 0) begin
         c.red = base.green;
         c.green = base.blue;
         c.blue = base.red;
      end else begin
         c.red = probe_channel(base.red);
         c.green = probe_channel(base.green);
         c.blue = probe_channel(base.blue);
      end
      return c;
   endfunction

   function automatic rgb_type detect_color(logic [PIXEL_INDEX_W-1:0] pix);
      rgb_type c;
      c.red = probe_channel(background_copy[pix].red);
      c.green = probe_channel(background_copy[pix].green);
      c.blue = probe_channel(background_copy[pix].blue);
      return c;
   endfunction

   function automatic logic [PIXEL_INDEX_W-1:0] pick_detect_pixel();
      logic [PIXEL_INDEX_W-1:0] p;
      do p = pixel_pool[$urandom_range(0, POOL_SIZE - 1)]; while (!background_written[p]);
      return p;
   endfunction

   function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, actual %0d", field, want, got);
         fail_count++;
      end
   endfunction

   task automatic send_pixel(input logic mode, input logic [PIXEL_INDEX_W-1:0] pix,
         input rgb_type px, input logic fe);
      if (send_gaps && !steady_tail && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= mode;
      req_tlast <= fe;
      req_tdata <= {4'b0, px.blue, px.green, px.red, pix};
      do @(posedge clock); while (!req_tready);
      expected_results.push_back(subtract_background(mode, pix, px, fe));
      words_sent++;
      if (mode == MODE_LEARN) learn_words++;
      else detect_words++;
   endtask

   task automatic send_detect();
      logic [PIXEL_INDEX_W-1:0] p;
      p = pick_detect_pixel();
      send_pixel(MODE_DETECT, p, detect_color(p), $urandom_range(0, 3) == 0);
   endtask

   task automatic wait_until_drained();
      req_tvalid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Writes both registers back to back; psel stays high between the two transfers.
   task automatic apply_settings(input logic [THRESHOLD_W-1:0] thr, input logic [RANK_W-1:0] rank);
      logic regsel;
      for (int i = 0; i < 2; i++) begin
         regsel = (i == 0) ? CSR_THRESHOLD_IDX : CSR_RANK_IDX;
         csr_psel <= 1'b1;
         csr_penable <= 1'b0;
         csr_pwrite <= 1'b1;
         csr_paddr <= {regsel, 2'b00};
         csr_pwdata <= (i == 0) ? CSR_DATA_W'(thr) : CSR_DATA_W'(rank);
         @(posedge clock);
         csr_penable <= 1'b1;
         do @(posedge clock); while (!csr_pready);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      threshold_now = thr;
      rank_now = rank;
      settings_used++;
   endtask

   task automatic run_learn_frame(input bit complete);
      logic [PIXEL_INDEX_W-1:0] order [$];
      logic [PIXEL_INDEX_W-1:0] held;
      int j;
      int len;
      int fe_at;
      logic fe;
      foreach (pixel_pool[i]) begin
         if (learn_allowed(pixel_pool[i])) order.push_back(pixel_pool[i]);
      end
      if (order.size() == 0) return;
      repeat ($urandom_range(0, 3)) order.push_back(order[$urandom_range(0, order.size() - 1)]);
      for (int i = order.size() - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         held = order[i];
         order[i] = order[j];
         order[j] = held;
      end
      len = order.size();
      if (!complete && len > 1) len = $urandom_range(1, (len < 8) ? len : 8);
      fe_at = complete ? len - 1 : $urandom_range(0, len);
      for (int i = 0; i < len; i++) begin
         if ($urandom_range(0, 3) == 0) send_detect();
         fe = (i == fe_at);
         send_pixel(MODE_LEARN, order[i], learn_color(order[i]), fe);
         if (fe) break;
      end
   endtask

   task automatic test_learn_extremes();
      send_pixel(MODE_LEARN, PIX_FIRST, '{8'h00, 8'h00, 8'h00}, 1'b0);
      send_pixel(MODE_LEARN, PIX_LAST, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
      send_pixel(MODE_LEARN, PIX_CHECKER, '{8'hAA, 8'h55, 8'hAA}, 1'b0);
      send_pixel(MODE_LEARN, TIE_PIXEL, learn_color(TIE_PIXEL), 1'b0);
   endtask

   task automatic test_detect_threshold();
      send_pixel(MODE_DETECT, PIX_FIRST, '{8'd31, 8'd31, 8'd31}, 1'b0);
      send_pixel(MODE_DETECT, PIX_FIRST, '{8'd0, 8'd32, 8'd0}, 1'b0);
      send_pixel(MODE_DETECT, PIX_LAST, '{8'd0, 8'd0, 8'd0}, 1'b0);
      send_pixel(MODE_DETECT, PIX_CHECKER, '{8'hAB, 8'h55, 8'hAA}, 1'b1);
      wait_until_drained();
      apply_settings(8'd0, RANK_RESET);
      send_pixel(MODE_DETECT, PIX_LAST, '{8'hFF, 8'hFF, 8'hFF}, 1'b0);
      wait_until_drained();
      apply_settings(8'd255, RANK_RESET);
      send_pixel(MODE_DETECT, PIX_FIRST, '{8'hFF, 8'h00, 8'h00}, 1'b0);
      send_pixel(MODE_DETECT, PIX_FIRST, '{8'h00, 8'h00, 8'hFE}, 1'b0);
      wait_until_drained();
      apply_settings(THRESHOLD_RESET, RANK_RESET);
   endtask

   // Every pool pixel must land in each slot while the history is still filling up.
   task automatic test_history_fill();
      while (frames_done < HIST) run_learn_frame(1'b1);
   endtask

   task automatic test_rank_ties();
      logic [RANK_W-1:0] ranks [3];
      ranks = '{4'd0, 4'd3, 4'd15};
      foreach (ranks[i]) begin
         wait_until_drained();
         apply_settings(THRESHOLD_RESET, ranks[i]);
         send_pixel(MODE_LEARN, TIE_PIXEL, learn_color(TIE_PIXEL), 1'b0);
         send_pixel(MODE_DETECT, TIE_PIXEL, detect_color(TIE_PIXEL), 1'b0);
      end
   endtask

   task automatic test_random_settings();
      logic [THRESHOLD_W-1:0] thr_list [PHASES];
      logic [RANK_W-1:0] rank_list [PHASES];
      int target;
      thr_list = '{8'd0, 8'd255, 8'd32, 8'd1, 8'd128, 8'd0, 8'd255, 8'd32};
      rank_list = '{4'd0, 4'd15, 4'd4, 4'd1, 4'd3, 4'd2, 4'd0, 4'd15};
      thr_list[3] = 8'($urandom);
      thr_list[5] = 8'($urandom_range(1, 64));
      rank_list[5] = 4'($urandom);
      for (int ph = 0; ph < PHASES; ph++) begin
         wait_until_drained();
         apply_settings(thr_list[ph], rank_list[ph]);
         if (ph == PHASES - 1) steady_tail = 1'b1;
         target = words_sent + (TOTAL_WORDS - words_sent) / (PHASES - ph);
         while (words_sent < target) begin
            send_gaps = ($urandom_range(0, 3) != 0);
            case ($urandom_range(0, 9))
               0, 1, 2, 3, 4, 5, 6: run_learn_frame(1'b1);
               7, 8: run_learn_frame(1'b0);
               default: repeat ($urandom_range(6, 16)) send_detect();
            endcase
         end
      end
   endtask

   always @(posedge clock) begin
      if ($urandom_range(0, 149) == 0) rsp_stalls_on = !rsp_stalls_on;
      if (steady_tail || !rsp_stalls_on) ready_hold = 0;
      else if (ready_hold > 0) ready_hold--;
      else if ($urandom_range(0, 4) == 0) ready_hold = $urandom_range(1, 11);
      rsp_tready <= (ready_hold == 0);
   end

   always @(posedge clock) begin
      pixel_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $error("result word arrived with no pending expectation");
            fail_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("red_out", want.color.red, rsp_tdata[7:0]);
            check_field("green_out", want.color.green, rsp_tdata[15:8]);
            check_field("blue_out", want.color.blue, rsp_tdata[23:16]);
            check_field("foreground", 8'(want.foreground), 8'(rsp_tuser));
            check_field("frame_end_out", 8'(want.frame_end), 8'(rsp_tlast));
            results_checked++;
            if (want.foreground) foreground_seen++;
         end
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
            (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
         $error("no word moved for %0d cycles, %0d results outstanding", idle_cycles,
               expected_results.size());
         $display("** median_background_subtractor_unit: FAILED **");
         $finish;
      end
   end

   initial begin
      logic [PIXEL_INDEX_W-1:0] cand;
      bit clash;
      pixel_pool[0] = PIX_FIRST;
      pixel_pool[1] = PIX_LAST;
      pixel_pool[2] = PIX_CHECKER;
      pixel_pool[3] = TIE_PIXEL;
      for (int i = 4; i < POOL_SIZE; i++) begin
         do begin
            cand = PIXEL_INDEX_W'($urandom_range(0, PIXELS - 1));
            clash = 1'b0;
            for (int k = 0; k < i; k++) if (pixel_pool[k] == cand) clash = 1'b1;
         end while (clash);
         pixel_pool[i] = cand;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_learn_extremes();
      test_detect_threshold();
      test_history_fill();
      test_rank_ties();
      test_random_settings();
      wait_until_drained();
      $display("Checked %0d result words from %0d learn and %0d detect pixel words.",
            results_checked, learn_words, detect_words);
      $display("%0d were foreground; %0d register settings ran, with rank and threshold extremes.",
            foreground_seen, settings_used);
      if (fail_count == 0) begin
         $display("** median_background_subtractor_unit: PASSED **");
      end else begin
         $display("** median_background_subtractor_unit: FAILED **");
      end
      $finish;
   end

endmodule
